FILE: src/tssd_pkg.sv
// Shared types, constants and register indexes of the steady-state detector.
package tssd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int PERIOD_BITS = 16;
   localparam int WINDOW_SUM_BITS = 19;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS = 16;
   localparam int CAPTURE_PORTS = 3;

   localparam int DEF_WINDOW_DEPTH = 5;
   localparam int DEF_CAPTURE_DEPTH = 3;

   // Band limits 0.95 and 1.05 of the average, scaled by 20 to integers.
   localparam int BAND_LOW_MUL = 19;
   localparam int BAND_HIGH_MUL = 21;
   localparam int BAND_SCALE = 20;

   localparam logic [PERIOD_BITS-1:0] CHECK_PERIOD_RESET = 16'd5000;
   localparam logic [PERIOD_BITS-1:0] MESSAGE_PERIOD_RESET = 16'd200;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [PERIOD_BITS-1:0] period_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type REG_CHECK_PERIOD = 8'd0;
   localparam csr_index_type REG_MESSAGE_PERIOD = 8'd1;

   typedef struct packed {
      logic message_pulse;
      logic check_done;
      logic in_band;
      logic steady;
      logic [WINDOW_SUM_BITS-1:0] window_sum;
      sample_type capture_newest;
      sample_type capture_middle;
      sample_type capture_oldest;
   } result_type;

endpackage

FILE: src/tssd_if.sv
// Channel interfaces: sample words in, result words out, register writes.
interface tssd_req_if import tssd_pkg::*; ();
   logic valid;
   logic ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface tssd_rsp_if import tssd_pkg::*; ();
   logic valid;
   logic ready;
   logic message_pulse;
   logic check_done;
   logic in_band;
   logic steady;
   logic [WINDOW_SUM_BITS-1:0] window_sum;
   sample_type capture_newest;
   sample_type capture_middle;
   sample_type capture_oldest;
   modport source (output valid, output message_pulse, output check_done, output in_band,
                   output steady, output window_sum, output capture_newest,
                   output capture_middle, output capture_oldest, input ready);
   modport sink (input valid, input message_pulse, input check_done, input in_band,
                 input steady, input window_sum, input capture_newest,
                 input capture_middle, input capture_oldest, output ready);
endinterface

interface tssd_csr_if import tssd_pkg::*; ();
   logic valid;
   logic ready;
   csr_index_type index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/tssd_tick_counter.sv
// Tick counter that counts advance strobes and fires and restarts when its period elapses.
module tssd_tick_counter import tssd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  period_type period,
   output logic       fire
);

   period_type count_ff;
   period_type count_in;
   period_type count_next;
   logic [PERIOD_BITS:0] count_plus;

   always_comb begin
      count_plus = {1'b0, count_ff} + {{PERIOD_BITS{1'b0}}, 1'b1};
      count_next = count_plus[PERIOD_BITS-1:0];
      // A period of zero, or one lowered below the count, fires at once.
      fire = (count_next >= period);
      if (advance) begin
         count_in = fire ? '0 : count_next;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: src/tick_scheduled_steady_state_detector_core.sv
// Top level of the tick-scheduled steady-state detector.
// Each accepted sample word is one tick and yields exactly one result word. A
// message pulse is raised every message_period ticks and a steady-state check
// runs every check_period ticks; a check shifts the sample into the window,
// forms the window sum from a running total, and tests 19*sum < 20*D*sample <
// 21*sum. In-band samples are pushed into the capture history and set the
// sticky steady flag. Throughput is one word per cycle while results are
// drained; the whole update sits between the request handshake and the result
// register, and a new word is taken whenever the result register is empty or
// is being drained in the same cycle. Register writes are taken at any time.
module tick_scheduled_steady_state_detector_core import tssd_pkg::*; #(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int CAPTURE_DEPTH = DEF_CAPTURE_DEPTH
) (
   input logic clock,
   input logic reset,
   tssd_req_if.sink req_chan,
   tssd_rsp_if.source rsp_chan,
   tssd_csr_if.sink csr_chan
);

   localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
   localparam int PROD_BITS = SUM_BITS + 5;
   localparam int WIDE_BITS = (SUM_BITS > WINDOW_SUM_BITS) ? SUM_BITS : WINDOW_SUM_BITS;
   localparam int SAMPLE_SCALE = BAND_SCALE * WINDOW_DEPTH;

   period_type check_period_ff;
   period_type message_period_ff;

   sample_type history_ff [WINDOW_DEPTH];
   sample_type captures_ff [CAPTURE_DEPTH];
   logic [SUM_BITS-1:0] history_total_ff;
   logic [SUM_BITS-1:0] history_total_in;
   logic steady_ff;
   logic steady_in;
   logic [WINDOW_SUM_BITS-1:0] last_sum_ff;
   logic [WINDOW_SUM_BITS-1:0] last_sum_in;

   result_type result_ff;
   result_type result_in;
   logic out_valid_ff;

   logic accept;
   logic message_fire;
   logic check_fire;
   logic do_check;
   logic band;
   logic [SUM_BITS-1:0] sum;
   logic [WIDE_BITS-1:0] sum_wide;
   logic [PROD_BITS-1:0] low_bound;
   logic [PROD_BITS-1:0] high_bound;
   logic [PROD_BITS-1:0] scaled;
   sample_type capture_view [CAPTURE_PORTS];

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_period_ff <= CHECK_PERIOD_RESET;
         message_period_ff <= MESSAGE_PERIOD_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_CHECK_PERIOD: check_period_ff <= csr_chan.data;
            REG_MESSAGE_PERIOD: message_period_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   tssd_tick_counter u_message_counter (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .period  (message_period_ff),
      .fire    (message_fire)
   );

   tssd_tick_counter u_check_counter (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .period  (check_period_ff),
      .fire    (check_fire)
   );

   assign do_check = accept && check_fire;

   always_comb begin
      // The oldest entry drops out of the window as the new sample enters.
      sum = history_total_ff - SUM_BITS'(history_ff[WINDOW_DEPTH-1])
            + SUM_BITS'(req_chan.sample);
      sum_wide = WIDE_BITS'(sum);
      low_bound = PROD_BITS'(sum) * PROD_BITS'(BAND_LOW_MUL);
      high_bound = PROD_BITS'(sum) * PROD_BITS'(BAND_HIGH_MUL);
      scaled = PROD_BITS'(req_chan.sample) * PROD_BITS'(SAMPLE_SCALE);
      band = check_fire && (low_bound < scaled) && (scaled < high_bound);
      history_total_in = check_fire ? sum : history_total_ff;
      last_sum_in = check_fire ? sum_wide[WINDOW_SUM_BITS-1:0] : last_sum_ff;
      steady_in = steady_ff || band;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            history_ff[k] <= '0;
         end
         for (int k = 0; k < CAPTURE_DEPTH; k++) begin
            captures_ff[k] <= '0;
         end
         history_total_ff <= '0;
         steady_ff <= 1'b0;
         last_sum_ff <= '0;
      end else if (accept) begin
         history_total_ff <= history_total_in;
         steady_ff <= steady_in;
         last_sum_ff <= last_sum_in;
         if (do_check) begin
            for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
               history_ff[k] <= history_ff[k-1];
            end
            history_ff[0] <= req_chan.sample;
         end
         if (band) begin
            for (int k = CAPTURE_DEPTH - 1; k > 0; k--) begin
               captures_ff[k] <= captures_ff[k-1];
            end
            captures_ff[0] <= req_chan.sample;
         end
      end
   end

   // Capture outputs see the history as it stands after this word.
   for (genvar g = 0; g < CAPTURE_PORTS; g++) begin : g_capture_view
      if (g == 0) begin : g_first
         assign capture_view[g] = band ? req_chan.sample : captures_ff[0];
      end else if (g < CAPTURE_DEPTH) begin : g_slot
         assign capture_view[g] = band ? captures_ff[g-1] : captures_ff[g];
      end else begin : g_empty
         assign capture_view[g] = '0;
      end
   end

   always_comb begin
      result_in.message_pulse = message_fire;
      result_in.check_done = check_fire;
      result_in.in_band = band;
      result_in.steady = steady_in;
      result_in.window_sum = last_sum_in;
      result_in.capture_newest = capture_view[0];
      result_in.capture_middle = capture_view[1];
      result_in.capture_oldest = capture_view[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.message_pulse = result_ff.message_pulse;
   assign rsp_chan.check_done = result_ff.check_done;
   assign rsp_chan.in_band = result_ff.in_band;
   assign rsp_chan.steady = result_ff.steady;
   assign rsp_chan.window_sum = result_ff.window_sum;
   assign rsp_chan.capture_newest = result_ff.capture_newest;
   assign rsp_chan.capture_middle = result_ff.capture_middle;
   assign rsp_chan.capture_oldest = result_ff.capture_oldest;

endmodule

FILE: bench/tssd_result_monitor.sv
// Monitor that predicts each result word of the steady-state detector and checks it.
module tssd_result_monitor import tssd_pkg::*; (
   input logic clock,
   input logic reset,
   tssd_req_if req_mon,
   tssd_rsp_if rsp_mon,
   tssd_csr_if csr_mon,
   output int mismatches,
   output int outstanding
);

   // Local copy of the registers and of the detector state.
   period_type check_period;
   period_type message_period;
   period_type check_count;
   period_type message_count;
   sample_type history [DEF_WINDOW_DEPTH];
   sample_type captures [DEF_CAPTURE_DEPTH];
   logic steady_flag;
   logic [WINDOW_SUM_BITS-1:0] last_sum;

   result_type tick_results_due [$];

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      end
   endtask

   // Advances both tick counters and, on a check tick, the window and, if in band, the captures.
   task automatic predict_tick(input sample_type s, output result_type r);
      period_type nxt;
      logic msg_fire;
      logic chk_fire;
      logic band;
      logic [31:0] sum;
      logic [31:0] scaled;
      int k;
      msg_fire = 1'b0;
      chk_fire = 1'b0;
      band = 1'b0;
      nxt = message_count + 1'b1;
      if (nxt >= message_period) begin
         message_count = '0;
         msg_fire = 1'b1;
      end else begin
         message_count = nxt;
      end
      nxt = check_count + 1'b1;
      if (nxt >= check_period) begin
         check_count = '0;
         chk_fire = 1'b1;
      end else begin
         check_count = nxt;
      end
      if (chk_fire) begin
         sum = 32'(s);
         for (k = DEF_WINDOW_DEPTH - 1; k > 0; k--) begin
            history[k] = history[k-1];
            sum += 32'(history[k]);
         end
         history[0] = s;
         scaled = 32'(BAND_SCALE * DEF_WINDOW_DEPTH) * 32'(s);
         band = (32'(BAND_LOW_MUL) * sum < scaled) && (scaled < 32'(BAND_HIGH_MUL) * sum);
         last_sum = sum[WINDOW_SUM_BITS-1:0];
         if (band) begin
            for (k = DEF_CAPTURE_DEPTH - 1; k > 0; k--) begin
               captures[k] = captures[k-1];
            end
            captures[0] = s;
            steady_flag = 1'b1;
         end
      end
      r.message_pulse = msg_fire;
      r.check_done = chk_fire;
      r.in_band = band;
      r.steady = steady_flag;
      r.window_sum = last_sum;
      r.capture_newest = captures[0];
      r.capture_middle = captures[1];
      r.capture_oldest = captures[2];
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type next_want;
      if (reset) begin
         check_period = CHECK_PERIOD_RESET;
         message_period = MESSAGE_PERIOD_RESET;
         check_count = '0;
         message_count = '0;
         foreach (history[k]) history[k] = '0;
         foreach (captures[k]) captures[k] = '0;
         steady_flag = 1'b0;
         last_sum = '0;
         tick_results_due.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_CHECK_PERIOD: check_period = csr_mon.data;
               REG_MESSAGE_PERIOD: message_period = csr_mon.data;
               default: ;
            endcase
         end
         // The oldest word is retired before this edge's new tick is queued.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (tick_results_due.size() == 0) begin
               report_mismatch("result word with no tick waiting for it");
            end else begin
               want = tick_results_due.pop_front();
               check_field("message_pulse", 32'(rsp_mon.message_pulse),
                           32'(want.message_pulse));
               check_field("check_done", 32'(rsp_mon.check_done), 32'(want.check_done));
               check_field("in_band", 32'(rsp_mon.in_band), 32'(want.in_band));
               check_field("steady", 32'(rsp_mon.steady), 32'(want.steady));
               check_field("window_sum", 32'(rsp_mon.window_sum), 32'(want.window_sum));
               check_field("capture_newest", 32'(rsp_mon.capture_newest),
                           32'(want.capture_newest));
               check_field("capture_middle", 32'(rsp_mon.capture_middle),
                           32'(want.capture_middle));
               check_field("capture_oldest", 32'(rsp_mon.capture_oldest),
                           32'(want.capture_oldest));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_tick(req_mon.sample, next_want);
            tick_results_due.push_back(next_want);
         end
      end
      outstanding <= tick_results_due.size();
   end

endmodule

FILE: bench/tb_tick_scheduled_steady_state_detector_core.sv
// Stimulus and verdict for the tick-scheduled steady-state detector.
module tb_tick_scheduled_steady_state_detector_core;
   import tssd_pkg::*;

   // An index that decodes to no register; the write must change nothing.
   localparam csr_index_type REG_UNMAPPED = 8'hA5;

   logic clock;
   logic reset;
   int mismatches;
   int outstanding;
   int stall_pct;
   logic pressure_on;
   int hold_left;
   logic hold_done;
   int run_left;
   int run_base;

   tssd_req_if req_bus ();
   tssd_rsp_if rsp_bus ();
   tssd_csr_if csr_bus ();

   tick_scheduled_steady_state_detector_core u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   tssd_result_monitor u_monitor (
      .clock(clock),
      .reset(reset),
      .req_mon(req_bus),
      .rsp_mon(rsp_bus),
      .csr_mon(csr_bus),
      .mismatches(mismatches),
      .outstanding(outstanding)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #(12 * 200000);
      $display("Test completed with failures");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off when a phase asks for it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (pressure_on && !hold_done) begin
         hold_left <= 150;
         hold_done <= 1'b1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Mostly runs around a held level, so that the window settles and checks pass.
   function automatic sample_type shaped_sample(input int noise_pct);
      int spread;
      int value;
      if ($urandom_range(99) < noise_pct) begin
         return sample_type'($urandom);
      end
      if (run_left == 0) begin
         run_left = $urandom_range(30, 6);
         case ($urandom_range(3))
            0: run_base = $urandom_range(255);
            1: run_base = $urandom_range(65535);
            2: run_base = $urandom_range(65535, 60000);
            default: run_base = $urandom_range(4000, 100);
         endcase
      end
      run_left--;
      spread = run_base / 40;
      value = run_base + $urandom_range(2 * spread) - spread;
      if (value < 0) value = 0;
      if (value > 65535) value = 65535;
      return sample_type'(value);
   endfunction

   // Called just after a rising edge; returns at the edge that takes the word.
   task automatic push_sample(input sample_type s, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample <= s;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
   endtask

   task automatic push_run(input sample_type s, input int count);
      repeat (count) push_sample(s, 0);
   endtask

   task automatic csr_beat(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(negedge clock); while (!csr_bus.ready);
      @(posedge clock);
   endtask

   task automatic configure(input period_type check_p, input period_type message_p);
      csr_beat(REG_CHECK_PERIOD, check_p);
      csr_beat(REG_MESSAGE_PERIOD, message_p);
      csr_bus.valid <= 1'b0;
   endtask

   // Drops valid and waits until every queued result word has been taken.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int idle_pct, input int stall,
                            input int noise_pct, input logic pressure);
      stall_pct <= stall;
      pressure_on <= pressure;
      repeat (count) push_sample(shaped_sample(noise_pct), idle_pct);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_CHECK_PERIOD;
      csr_bus.data = '0;
      stall_pct = 0;
      pressure_on = 1'b0;
      run_left = 0;
      run_base = 0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset periods: extremes of the sample, then enough ticks for a message pulse.
      push_sample(16'd0, 0);
      push_sample(16'hFFFF, 0);
      push_sample(16'd0, 0);
      push_sample(16'hFFFF, 0);
      push_sample(16'd1, 0);
      run_phase(205, 0, 0, 20, 1'b0);
      wait_idle();

      // Zero periods act as one: both events fire on every tick.
      csr_beat(REG_UNMAPPED, 16'hFFFF);
      configure(16'd0, 16'd0);
      // The window is still empty here, so the first checks must fail.
      push_run(16'd0, 2);
      push_run(16'hFFFF, 5);
      // Just outside, just inside, inside and outside the band around 100.
      push_run(16'd100, 4);
      push_sample(16'd93, 0);
      push_run(16'd100, 4);
      push_sample(16'd94, 0);
      push_run(16'd100, 4);
      push_sample(16'd106, 0);
      push_run(16'd100, 4);
      push_sample(16'd107, 0);
      wait_idle();

      configure(16'hFFFF, 16'hFFFF);
      run_phase(40, 61, 0, 20, 1'b0);
      wait_idle();

      // Both counters now sit above the new periods and must fire on the next tick.
      configure(16'd7, 16'd3);
      run_phase(150, 0, 0, 20, 1'b1);
      wait_idle();

      configure(16'd1, 16'd2);
      run_phase(200, 24, 24, 20, 1'b0);
      wait_idle();

      configure(16'd2, 16'd1);
      run_phase(150, 0, 61, 20, 1'b0);
      wait_idle();

      configure(16'd1, 16'd5000);
      run_phase(150, 61, 0, 20, 1'b0);
      wait_idle();

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
